FILE: rtl/core/rtc_calendar_decode_to_epoch_macros.svh
// Assertion helpers for the calendar decoder RTL.
`ifndef RTC_CALENDAR_DECODE_TO_EPOCH_MACROS_SVH
`define RTC_CALENDAR_DECODE_TO_EPOCH_MACROS_SVH

// Check on every clock edge outside reset; expects clk and arst_n in scope.
`define RTCDE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define RTCDE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/rtcde_pkg.sv
`default_nettype none
package rtcde_pkg;

	// Calendar constants
	localparam int BASE_YEAR = 2000;
	localparam int YEAR_MIN = 2000;
	localparam int YEAR_MAX = 2099;

	// Era handling for years 1999..2099 (year shifted back for Jan and Feb)
	localparam int ERA_BASE_HI = 2000;
	localparam int ERA_BASE_LO = 1600;
	localparam int DAYS_PER_ERA = 146097;
	localparam int EPOCH_SHIFT = 719468;
	localparam int ERA_OFS_HI = 5 * DAYS_PER_ERA - EPOCH_SHIFT;
	localparam int ERA_OFS_LO = EPOCH_SHIFT - 4 * DAYS_PER_ERA;

	// Field widths
	localparam int RAW_W = 8;
	localparam int SEC_W = 6;
	localparam int MIN_W = 6;
	localparam int HOUR_W = 5;
	localparam int DAY_W = 5;
	localparam int MON_W = 4;
	localparam int YEAR_W = 12;
	localparam int SECS_W = 32;
	localparam int DAYS_W = 16;
	localparam int YOE_W = 9;
	localparam int DOY_W = 9;
	localparam int DOE_W = 18;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_BINARY_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HOUR24_MODE = CFG_IDX_W'(1);

	// Queue between decode and conversion (power of two)
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	typedef struct packed {
		logic binary_mode;
		logic hour24_mode;
	} cfg_t;

	typedef struct packed {
		logic              ok;
		logic [SEC_W-1:0]  sec;
		logic [MIN_W-1:0]  min;
		logic [HOUR_W-1:0] hour;
		logic [DAY_W-1:0]  day;
		logic [MON_W-1:0]  mon;
		logic [YEAR_W-1:0] year;
	} item_t;

	// Days from March 1 to the first of the shifted month: (153*mp+2)/5
	function automatic logic [DOY_W-1:0] doy_base(input logic [MON_W-1:0] mp);
		logic [DOY_W-1:0] r;
		case (mp)
			4'd0:    r = DOY_W'(0);
			4'd1:    r = DOY_W'(31);
			4'd2:    r = DOY_W'(61);
			4'd3:    r = DOY_W'(92);
			4'd4:    r = DOY_W'(122);
			4'd5:    r = DOY_W'(153);
			4'd6:    r = DOY_W'(184);
			4'd7:    r = DOY_W'(214);
			4'd8:    r = DOY_W'(245);
			4'd9:    r = DOY_W'(275);
			4'd10:   r = DOY_W'(306);
			4'd11:   r = DOY_W'(337);
			default: r = DOY_W'(0);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rtc_calendar_decode_to_epoch.sv
// Path from input transfer to result valid: decode register (loaded at
// the transfer edge), then queue slot, day-count register, output register.
// Throughput: one reading per cycle while in_stall is low; the 4-entry queue absorbs output stalls.
// Reset (arst_n low, asynchronous): pipeline and queue empty, binary_mode 0,
// hour24_mode 1. Configuration writes are taken every cycle.
`default_nettype none
module rtc_calendar_decode_to_epoch (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rtcde_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rtcde_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [rtcde_pkg::RAW_W-1:0]       seconds_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]       minutes_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]       hours_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]       weekday_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]       day_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]       month_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]       year_raw,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   valid_res,
	output logic [rtcde_pkg::SECS_W-1:0]           unix_seconds,
	output logic [rtcde_pkg::SEC_W-1:0]            second_out,
	output logic [rtcde_pkg::MIN_W-1:0]            minute_out,
	output logic [rtcde_pkg::HOUR_W-1:0]           hour_out,
	output logic [rtcde_pkg::DAY_W-1:0]            day_out,
	output logic [rtcde_pkg::MON_W-1:0]            month_out,
	output logic [rtcde_pkg::YEAR_W-1:0]           year_out
);

	rtcde_pkg::cfg_t   cfg_q;
	logic              q_full;
	logic              q_push;
	logic              q_pop;
	logic              q_nonempty;
	rtcde_pkg::item_t  push_item;
	rtcde_pkg::item_t  head_item;

	assign cfg_ready = 1'b1;

	// Update mode registers; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.binary_mode <= 1'b0;
			cfg_q.hour24_mode <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rtcde_pkg::REG_BINARY_MODE: cfg_q.binary_mode <= cfg_data[0];
				rtcde_pkg::REG_HOUR24_MODE: cfg_q.hour24_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	rtcde_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.seconds_raw (seconds_raw),
		.minutes_raw (minutes_raw),
		.hours_raw   (hours_raw),
		.weekday_raw (weekday_raw),
		.day_raw     (day_raw),
		.month_raw   (month_raw),
		.year_raw    (year_raw),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (push_item)
	);

	rtcde_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_i   (push_item),
		.pop      (q_pop),
		.item_o   (head_item),
		.full     (q_full),
		.nonempty (q_nonempty)
	);

	rtcde_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_item       (head_item),
		.q_nonempty   (q_nonempty),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.valid_res    (valid_res),
		.unix_seconds (unix_seconds),
		.second_out   (second_out),
		.minute_out   (minute_out),
		.hour_out     (hour_out),
		.day_out      (day_out),
		.month_out    (month_out),
		.year_out     (year_out)
	);

endmodule
`default_nettype wire

FILE: rtl/core/rtcde_front.sv
`default_nettype none
module rtcde_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rtcde_pkg::cfg_t               cfg,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [rtcde_pkg::RAW_W-1:0]   seconds_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]   minutes_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]   hours_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]   weekday_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]   day_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]   month_raw,
	input  wire logic [rtcde_pkg::RAW_W-1:0]   year_raw,
	input  wire logic                          q_full,
	output logic                               q_push,
	output rtcde_pkg::item_t                   q_item
);

	function automatic logic nib_ok(input logic [rtcde_pkg::RAW_W-1:0] v);
		return (v[3:0] <= 4'd9) && (v[7:4] <= 4'd9);
	endfunction

	function automatic logic [rtcde_pkg::RAW_W-1:0] take(
		input logic                          bin,
		input logic [rtcde_pkg::RAW_W-1:0]   v
	);
		logic [rtcde_pkg::RAW_W-1:0] dec;
		dec = {4'd0, v[3:0]} + {1'b0, v[7:4], 3'd0} + {3'd0, v[7:4], 1'b0};
		return bin ? v : dec;
	endfunction

	logic [rtcde_pkg::RAW_W-1:0]    hraw;
	logic                           pm;
	logic                           enc_ok;
	logic [rtcde_pkg::RAW_W-1:0]    sec_v;
	logic [rtcde_pkg::RAW_W-1:0]    min_v;
	logic [rtcde_pkg::RAW_W-1:0]    hr_v;
	logic [rtcde_pkg::RAW_W-1:0]    day_v;
	logic [rtcde_pkg::RAW_W-1:0]    mon_v;
	logic [rtcde_pkg::RAW_W-1:0]    hr12;
	logic [rtcde_pkg::RAW_W:0]      hour_v;
	logic [rtcde_pkg::YEAR_W-1:0]   year_v;
	logic                           range_ok;
	rtcde_pkg::item_t               item_d;
	logic                           accept;
	logic                           valid_s1;
	rtcde_pkg::item_t               item_s1;

	// Strip the PM flag in 12-hour mode
	assign pm   = !cfg.hour24_mode && hours_raw[7];
	assign hraw = cfg.hour24_mode ? hours_raw : {1'b0, hours_raw[6:0]};

	// Check BCD nibbles of all seven bytes
	assign enc_ok = cfg.binary_mode ||
		(nib_ok(seconds_raw) && nib_ok(minutes_raw) && nib_ok(hraw) &&
		 nib_ok(weekday_raw) && nib_ok(day_raw) && nib_ok(month_raw) &&
		 nib_ok(year_raw));

	// Decode fields
	assign sec_v  = take(cfg.binary_mode, seconds_raw);
	assign min_v  = take(cfg.binary_mode, minutes_raw);
	assign hr_v   = take(cfg.binary_mode, hraw);
	assign day_v  = take(cfg.binary_mode, day_raw);
	assign mon_v  = take(cfg.binary_mode, month_raw);
	assign year_v = {4'd0, take(cfg.binary_mode, year_raw)} +
		rtcde_pkg::YEAR_W'(rtcde_pkg::BASE_YEAR);

	// Convert 12-hour time: 12 AM is hour 0, PM adds 12
	assign hr12   = (hr_v == 8'd12) ? 8'd0 : hr_v;
	assign hour_v = cfg.hour24_mode ? {1'b0, hr_v} :
		({1'b0, hr12} + (pm ? 9'd12 : 9'd0));

	// Range-check decoded fields
	assign range_ok = (sec_v <= 8'd59) && (min_v <= 8'd59) && (hour_v <= 9'd23) &&
		(day_v >= 8'd1) && (day_v <= 8'd31) && (mon_v >= 8'd1) && (mon_v <= 8'd12) &&
		(year_v >= rtcde_pkg::YEAR_W'(rtcde_pkg::YEAR_MIN)) &&
		(year_v <= rtcde_pkg::YEAR_W'(rtcde_pkg::YEAR_MAX));

	always_comb begin
		item_d      = '0;
		item_d.ok   = enc_ok && range_ok;
		item_d.sec  = sec_v[rtcde_pkg::SEC_W-1:0];
		item_d.min  = min_v[rtcde_pkg::MIN_W-1:0];
		item_d.hour = hour_v[rtcde_pkg::HOUR_W-1:0];
		item_d.day  = day_v[rtcde_pkg::DAY_W-1:0];
		item_d.mon  = mon_v[rtcde_pkg::MON_W-1:0];
		item_d.year = year_v;
	end

	// Hold the input while the decoded item cannot enter the queue
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/rtcde_queue.sv
`default_nettype none
`include "rtc_calendar_decode_to_epoch_macros.svh"
module rtcde_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire rtcde_pkg::item_t  item_i,
	input  wire logic              pop,
	output rtcde_pkg::item_t       item_o,
	output logic                   full,
	output logic                   nonempty
);

	rtcde_pkg::item_t               mem_q [rtcde_pkg::Q_DEPTH];
	logic [rtcde_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [rtcde_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [rtcde_pkg::Q_PTR_W:0]    count_q;

	assign full     = (count_q == (rtcde_pkg::Q_PTR_W+1)'(rtcde_pkg::Q_DEPTH));
	assign nonempty = (count_q != '0);
	assign item_o   = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_i;
		end
	end

	`RTCDE_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
	`RTCDE_ASSERT(a_no_pop_empty, pop |-> nonempty, "pop from empty queue")
	`RTCDE_ASSERT(a_push_fills, (push && !pop) |=> nonempty, "push did not fill queue")
	`RTCDE_ASSERT_ALWAYS(a_count_bound, !arst_n || (count_q <= (rtcde_pkg::Q_PTR_W+1)'(rtcde_pkg::Q_DEPTH)), "queue count over depth")

endmodule
`default_nettype wire

FILE: rtl/core/rtcde_back.sv
`default_nettype none
module rtcde_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire rtcde_pkg::item_t              q_item,
	input  wire logic                          q_nonempty,
	output logic                               q_pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               valid_res,
	output logic [rtcde_pkg::SECS_W-1:0]       unix_seconds,
	output logic [rtcde_pkg::SEC_W-1:0]        second_out,
	output logic [rtcde_pkg::MIN_W-1:0]        minute_out,
	output logic [rtcde_pkg::HOUR_W-1:0]       hour_out,
	output logic [rtcde_pkg::DAY_W-1:0]        day_out,
	output logic [rtcde_pkg::MON_W-1:0]        month_out,
	output logic [rtcde_pkg::YEAR_W-1:0]       year_out
);

	logic                           le2;
	logic [rtcde_pkg::YEAR_W-1:0]   y;
	logic                           era5;
	logic [rtcde_pkg::YOE_W-1:0]    yoe;
	logic [rtcde_pkg::MON_W-1:0]    mp;
	logic [rtcde_pkg::DOY_W-1:0]    doy;
	logic [1:0]                     cent;
	logic [rtcde_pkg::DOE_W-1:0]    doe;
	logic [rtcde_pkg::DAYS_W-1:0]   days_d;
	logic                           ready_s3;
	logic                           ready_s2;
	logic                           valid_s2;
	rtcde_pkg::item_t               item_s2;
	logic [rtcde_pkg::DAYS_W-1:0]   days_s2;
	logic [rtcde_pkg::SECS_W-1:0]   secs_d;
	logic                           valid_s3;

	// Shift the year so the leap day ends it
	assign le2  = (q_item.mon <= 4'd2);
	assign y    = q_item.year - {11'd0, le2};
	assign era5 = (y >= rtcde_pkg::YEAR_W'(rtcde_pkg::ERA_BASE_HI));
	assign yoe  = era5 ? rtcde_pkg::YOE_W'(y - rtcde_pkg::YEAR_W'(rtcde_pkg::ERA_BASE_HI)) :
		rtcde_pkg::YOE_W'(y - rtcde_pkg::YEAR_W'(rtcde_pkg::ERA_BASE_LO));
	assign mp   = (q_item.mon > 4'd2) ? (q_item.mon - 4'd3) : (q_item.mon + 4'd9);
	assign doy  = rtcde_pkg::doy_base(mp) + rtcde_pkg::DOY_W'(q_item.day) - 9'd1;
	assign cent = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 :
		(yoe >= 9'd100) ? 2'd1 : 2'd0;

	// Day of era, then days since the epoch
	assign doe = rtcde_pkg::DOE_W'(yoe) * rtcde_pkg::DOE_W'(365) +
		rtcde_pkg::DOE_W'(yoe[rtcde_pkg::YOE_W-1:2]) - rtcde_pkg::DOE_W'(cent) +
		rtcde_pkg::DOE_W'(doy);
	assign days_d = era5 ?
		rtcde_pkg::DAYS_W'(doe + rtcde_pkg::DOE_W'(rtcde_pkg::ERA_OFS_HI)) :
		rtcde_pkg::DAYS_W'(doe - rtcde_pkg::DOE_W'(rtcde_pkg::ERA_OFS_LO));

	// Stage readiness from the output side back
	assign ready_s3 = !valid_s3 || !out_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign q_pop    = q_nonempty && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= q_nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s2 <= q_item;
			days_s2 <= days_d;
		end
	end

	// Combine days and time of day
	assign secs_d = rtcde_pkg::SECS_W'(days_s2) * 32'd86400 +
		rtcde_pkg::SECS_W'(item_s2.hour) * 32'd3600 +
		rtcde_pkg::SECS_W'(item_s2.min) * 32'd60 +
		rtcde_pkg::SECS_W'(item_s2.sec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	// Zero every field of a rejected reading
	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			valid_res    <= item_s2.ok;
			unix_seconds <= item_s2.ok ? secs_d : '0;
			second_out   <= item_s2.ok ? item_s2.sec : '0;
			minute_out   <= item_s2.ok ? item_s2.min : '0;
			hour_out     <= item_s2.ok ? item_s2.hour : '0;
			day_out      <= item_s2.ok ? item_s2.day : '0;
			month_out    <= item_s2.ok ? item_s2.mon : '0;
			year_out     <= item_s2.ok ? item_s2.year : '0;
		end
	end

	assign out_valid = valid_s3;

endmodule
`default_nettype wire
